// ===== sv/tmtw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer package
// Shared types, codes and defaults for the character terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam logic [7:0] ATTR_RESET     = 8'h07;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_BLANK     = 8'h20;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } result_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_MEM,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } back_state_t;

endpackage

// ===== sv/tmtw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer front end
// Accepts items, decodes them into operations and hands them to the queue.
// ----------------------------------------------------------------------------
module tmtw_front #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tmtw_pkg::item_t   item,
    output logic              busy,
    input  logic              initializing,
    input  logic              queue_full,
    output logic              push,
    output tmtw_pkg::cmd_t    push_cmd
);

    logic            front_valid_reg;
    logic            front_valid_next;
    tmtw_pkg::cmd_t  front_reg;
    tmtw_pkg::cmd_t  decoded;
    logic            accept;

    assign busy     = initializing || (front_valid_reg && queue_full);
    assign accept   = start && !busy;
    assign push     = front_valid_reg && !queue_full;
    assign push_cmd = front_reg;

    always_comb
    begin
        decoded.char_code = item.char_code;
        decoded.read_row  = item.read_row;
        decoded.read_col  = item.read_col;
        unique case (item.kind)
            tmtw_pkg::KIND_PUT:
            begin
                if (item.char_code == tmtw_pkg::CODE_NEWLINE)
                begin
                    decoded.op = tmtw_pkg::OP_NEWLINE;
                end
                else if (item.char_code == tmtw_pkg::CODE_BACKSPACE)
                begin
                    decoded.op = tmtw_pkg::OP_BACKSPACE;
                end
                else
                begin
                    decoded.op = tmtw_pkg::OP_PUT;
                end
            end
            tmtw_pkg::KIND_READ:
            begin
                if ((int'(item.read_row) < ROWS) && (int'(item.read_col) < COLUMNS))
                begin
                    decoded.op = tmtw_pkg::OP_READ;
                end
                else
                begin
                    decoded.op = tmtw_pkg::OP_NOP;
                end
            end
            tmtw_pkg::KIND_CLEAR:
            begin
                decoded.op = tmtw_pkg::OP_CLEAR;
            end
            default:
            begin
                decoded.op = tmtw_pkg::OP_NOP;
            end
        endcase
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg <= decoded;
        end
    end

endmodule

// ===== sv/tmtw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer command queue
// Short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module tmtw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tmtw_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tmtw_pkg::cmd_t  pop_cmd
);

    tmtw_pkg::cmd_t                      entries [tmtw_pkg::QUEUE_DEPTH];
    logic [tmtw_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [tmtw_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [tmtw_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [tmtw_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [tmtw_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [tmtw_pkg::QUEUE_CNT_W-1:0]    count_next;

    localparam logic [tmtw_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        tmtw_pkg::QUEUE_PTR_W'(tmtw_pkg::QUEUE_DEPTH - 1);
    localparam logic [tmtw_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        tmtw_pkg::QUEUE_CNT_W'(tmtw_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/tmtw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer back end
// Sequencer that owns the cursor, the line ring and the screen memory.
// ----------------------------------------------------------------------------
module tmtw_back #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         attribute,
    input  logic               cmd_valid,
    input  tmtw_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               initializing,
    output logic               done,
    output tmtw_pkg::result_t  result
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W:0]    ROWS_WIDE = (ROW_W + 1)'(ROWS);

    logic [15:0] screen [CELLS];
    logic [15:0] rd_q;
    logic        mem_we;
    logic [15:0] mem_wdata;

    tmtw_pkg::back_state_t state_reg, state_next;
    tmtw_pkg::cmd_t        cmd_reg, cmd_next;
    logic [ROW_W-1:0]      cur_row_reg, cur_row_next;
    logic [COL_W-1:0]      cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]      top_reg, top_next;
    logic [ROW_W-1:0]      phys_reg, phys_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  wr_reg, wr_next;
    logic                  rd_reg, rd_next;
    logic [15:0]           wdata_reg, wdata_next;
    logic                  scroll_reg, scroll_next;
    logic [ROW_W-1:0]      blank_row_reg, blank_row_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COL_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    tmtw_pkg::result_t     result_reg, result_next;

    logic [ROW_W-1:0]      tgt_row;
    logic [ROW_W:0]        row_sum;
    logic                  wrap;

    assign initializing = (state_reg == tmtw_pkg::S_INIT);
    assign cmd_pop      = (state_reg == tmtw_pkg::S_IDLE) && cmd_valid;
    assign done         = done_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        phys_next      = phys_reg;
        col_next       = col_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        wdata_next     = wdata_reg;
        scroll_next    = scroll_reg;
        blank_row_next = blank_row_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_wdata      = {attribute, tmtw_pkg::CODE_BLANK};
        tgt_row        = cur_row_reg;
        row_sum        = '0;
        wrap           = 1'b0;

        unique case (state_reg)
            tmtw_pkg::S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tmtw_pkg::ATTR_RESET, tmtw_pkg::CODE_BLANK};
                addr_next = addr_reg + 1'b1;
                if (addr_reg == CELL_LAST)
                begin
                    state_next = tmtw_pkg::S_IDLE;
                end
            end
            tmtw_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = tmtw_pkg::S_CALC;
                end
            end
            tmtw_pkg::S_CALC:
            begin
                col_next    = cur_col_reg;
                wr_next     = 1'b0;
                rd_next     = 1'b0;
                scroll_next = 1'b0;
                wdata_next  = {attribute, tmtw_pkg::CODE_BLANK};
                state_next  = tmtw_pkg::S_ADDR;
                unique case (cmd_reg.op)
                    tmtw_pkg::OP_PUT:
                    begin
                        wr_next      = 1'b1;
                        wdata_next   = {attribute, cmd_reg.char_code};
                        wrap         = (cur_col_reg == COL_LAST);
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                    tmtw_pkg::OP_NEWLINE:
                    begin
                        wrap = 1'b1;
                    end
                    tmtw_pkg::OP_BACKSPACE:
                    begin
                        wr_next = 1'b1;
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - 1'b1;
                            col_next     = cur_col_reg - 1'b1;
                        end
                        else if (cur_row_reg != '0)
                        begin
                            cur_row_next = cur_row_reg - 1'b1;
                            cur_col_next = COL_LAST;
                            tgt_row      = cur_row_reg - 1'b1;
                            col_next     = COL_LAST;
                        end
                    end
                    tmtw_pkg::OP_READ:
                    begin
                        rd_next  = 1'b1;
                        tgt_row  = ROW_W'(cmd_reg.read_row);
                        col_next = COL_W'(cmd_reg.read_col);
                    end
                    tmtw_pkg::OP_CLEAR:
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                        top_next     = '0;
                        addr_next    = '0;
                        state_next   = tmtw_pkg::S_CLEAR;
                    end
                    default:
                    begin
                        state_next = tmtw_pkg::S_DONE;
                    end
                endcase
                if (wrap)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == ROW_LAST)
                    begin
                        scroll_next    = 1'b1;
                        blank_row_next = top_reg;
                        top_next       = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                row_sum   = {1'b0, top_reg} + {1'b0, tgt_row};
                phys_next = (row_sum >= ROWS_WIDE) ? ROW_W'(row_sum - ROWS_WIDE)
                                                   : ROW_W'(row_sum);
            end
            tmtw_pkg::S_ADDR:
            begin
                addr_next  = ADDR_W'(phys_reg * COLUMNS) + ADDR_W'(col_reg);
                state_next = tmtw_pkg::S_MEM;
            end
            tmtw_pkg::S_MEM:
            begin
                mem_we    = wr_reg;
                mem_wdata = wdata_reg;
                if (scroll_reg)
                begin
                    addr_next  = ADDR_W'(blank_row_reg * COLUMNS);
                    cnt_next   = '0;
                    state_next = tmtw_pkg::S_SCROLL;
                end
                else
                begin
                    state_next = tmtw_pkg::S_DONE;
                end
            end
            tmtw_pkg::S_SCROLL:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == COL_LAST)
                begin
                    state_next = tmtw_pkg::S_DONE;
                end
            end
            tmtw_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == CELL_LAST)
                begin
                    state_next = tmtw_pkg::S_DONE;
                end
            end
            tmtw_pkg::S_DONE:
            begin
                done_next              = 1'b1;
                result_next.read_data  = rd_reg ? rd_q : 16'h0000;
                result_next.cursor_row = 5'(cur_row_reg);
                result_next.cursor_col = 7'(cur_col_reg);
                result_next.scrolled   = scroll_reg;
                rd_next                = 1'b0;
                scroll_next            = 1'b0;
                state_next             = tmtw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tmtw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tmtw_pkg::S_INIT;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            rd_reg      <= 1'b0;
            wr_reg      <= 1'b0;
            scroll_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            top_reg     <= top_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            scroll_reg  <= scroll_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        phys_reg      <= phys_next;
        col_reg       <= col_next;
        wdata_reg     <= wdata_next;
        blank_row_reg <= blank_row_next;
        result_reg    <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen[addr_reg] <= mem_wdata;
        end
        rd_q <= screen[addr_reg];
    end

endmodule

// ===== sv/text_mode_terminal_writer_unit.sv =====
`timescale 1ns / 1ps
// A character, newline, backspace or in-range read beat runs through the back-end
// states calc, address, memory and done before its result strobe; a scroll adds a
// sweep of one row to blanks. A clear goes from calc to a sweep of the whole screen
// and then to done, other beats straight from calc to done. The back-end sequencer
// takes a new command only when idle, and with its single screen memory port sets
// the pace; a two-entry queue absorbs short bursts. Reset: the screen memory is
// swept to blanks, one cell a cycle, with busy high. Results cannot stall.
// ----------------------------------------------------------------------------
// Text terminal writer
// Character terminal with cursor, scrolling line ring and screen memory.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_unit #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tmtw_pkg::item_t    item,
    output logic               done,
    output tmtw_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    logic [7:0]      attribute_reg;
    logic [7:0]      attribute_next;
    logic            initializing;
    logic            queue_full;
    logic            push;
    tmtw_pkg::cmd_t  push_cmd;
    logic            pop;
    logic            not_empty;
    tmtw_pkg::cmd_t  pop_cmd;

    assign cfg_ready      = 1'b1;
    assign attribute_next = (cfg_valid && cfg_ready) ? cfg_data : attribute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= tmtw_pkg::ATTR_RESET;
        end
        else
        begin
            attribute_reg <= attribute_next;
        end
    end

    tmtw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .initializing (initializing),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tmtw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_cmd   (pop_cmd)
    );

    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .attribute    (attribute_reg),
        .cmd_valid    (not_empty),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .initializing (initializing),
        .done         (done),
        .result       (result)
    );

endmodule

// ===== tb/sv/tmtw_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal writer result checker
// Watches the command, result and attribute channels of the terminal writer.
// It keeps its own copy of the screen, cursor, line ring and attribute,
// predicts the result of every accepted beat and compares each result strobe,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tmtw_result_checker #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  tmtw_pkg::item_t    item,
    input  logic               done,
    input  tmtw_pkg::result_t  result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output int                 mismatch_count,
    output int                 pending_count
);

    localparam int CELLS = ROWS * COLUMNS;

    logic [15:0]        screen [CELLS];
    int unsigned        top_line;
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [7:0]         attr;
    tmtw_pkg::result_t  expected_results [$];

    function automatic int unsigned cell_addr(input int unsigned row, input int unsigned col);
        return ((top_line + row) % ROWS) * COLUMNS + col;
    endfunction

    task automatic fill_screen(input logic [7:0] fill_attr);
        for (int i = 0; i < CELLS; i++)
            screen[i] = {fill_attr, tmtw_pkg::CODE_BLANK};
    endtask

    task automatic advance_line(output logic scrolled);
        scrolled = 1'b0;
        cur_col  = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            top_line = (top_line + 1) % ROWS;
            cur_row  = ROWS - 1;
            for (int c = 0; c < COLUMNS; c++)
                screen[cell_addr(cur_row, c)] = {attr, tmtw_pkg::CODE_BLANK};
            scrolled = 1'b1;
        end
    endtask

    task automatic predict_terminal(input tmtw_pkg::item_t it, output tmtw_pkg::result_t r);
        logic sc;
        sc = 1'b0;
        r  = '0;
        case (it.kind)
            tmtw_pkg::KIND_PUT:
            begin
                if (it.char_code == tmtw_pkg::CODE_NEWLINE)
                begin
                    advance_line(sc);
                end
                else if (it.char_code == tmtw_pkg::CODE_BACKSPACE)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                    end
                    else if (cur_row > 0)
                    begin
                        cur_row--;
                        cur_col = COLUMNS - 1;
                    end
                    screen[cell_addr(cur_row, cur_col)] = {attr, tmtw_pkg::CODE_BLANK};
                end
                else
                begin
                    screen[cell_addr(cur_row, cur_col)] = {attr, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        advance_line(sc);
                end
            end
            tmtw_pkg::KIND_READ:
            begin
                if (it.read_row < ROWS && it.read_col < COLUMNS)
                    r.read_data = screen[cell_addr(it.read_row, it.read_col)];
            end
            tmtw_pkg::KIND_CLEAR:
            begin
                top_line = 0;
                cur_row  = 0;
                cur_col  = 0;
                fill_screen(attr);
            end
            default:
            begin
            end
        endcase
        r.cursor_row = cur_row[4:0];
        r.cursor_col = cur_col[6:0];
        r.scrolled   = sc;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tmtw_pkg::result_t exp_r;
        tmtw_pkg::result_t pred_r;
        if (!rst_n)
        begin
            attr     = tmtw_pkg::ATTR_RESET;
            top_line = 0;
            cur_row  = 0;
            cur_col  = 0;
            fill_screen(tmtw_pkg::ATTR_RESET);
            expected_results.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting: %h", result);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.read_data !== exp_r.read_data)
                    begin
                        $error("read_data: expected %h, actual %h",
                               exp_r.read_data, result.read_data);
                        mismatch_count++;
                    end
                    if (result.cursor_row !== exp_r.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, actual %0d",
                               exp_r.cursor_row, result.cursor_row);
                        mismatch_count++;
                    end
                    if (result.cursor_col !== exp_r.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, actual %0d",
                               exp_r.cursor_col, result.cursor_col);
                        mismatch_count++;
                    end
                    if (result.scrolled !== exp_r.scrolled)
                    begin
                        $error("scrolled: expected %0d, actual %0d",
                               exp_r.scrolled, result.scrolled);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                attr = cfg_data;
            if (start && !busy)
            begin
                predict_terminal(item, pred_r);
                expected_results.push_back(pred_r);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal writer testbench
// Drives directed and random command beats into the terminal writer, with
// random gaps and attribute changes between phases, and lets the checker
// predict and compare every result. Ends with a single verdict line.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         COLUMNS     = tmtw_pkg::COLUMNS_DEFAULT;
    localparam int         ROWS        = tmtw_pkg::ROWS_DEFAULT;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 140;
    localparam int         CYCLE_LIMIT = 400000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    tmtw_pkg::item_t    item      = '0;
    logic               cfg_valid = 1'b0;
    logic [7:0]         cfg_data  = 8'h00;
    logic               busy;
    logic               done;
    tmtw_pkg::result_t  result;
    logic               cfg_ready;
    int                 mismatch_count;
    int                 pending_count;
    int                 cycle_count = 0;

    text_mode_terminal_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tmtw_result_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] kind, input logic [7:0] code,
                         input logic [4:0] row, input logic [6:0] col);
        @(negedge clk);
        start          <= 1'b1;
        item.kind      <= kind;
        item.char_code <= code;
        item.read_row  <= row;
        item.read_col  <= col;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain();
        pause(1);
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0] attr_value;
        logic [1:0] kind;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
        int         sel;
        int         sub;
        bit         no_idle;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset attribute.
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, tmtw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, 8'h41, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, 8'hFF, 5'd31, 7'd127);
        issue(tmtw_pkg::KIND_PUT, 8'h00, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, tmtw_pkg::CODE_NEWLINE, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, tmtw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, 8'h5A, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd0, 7'd79);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd24, 7'd79);
        issue(tmtw_pkg::KIND_READ, 8'hFF, 5'd31, 7'd127);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd25, 7'd0);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd0, 7'd80);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd0, 7'd2);
        issue(KIND_UNUSED, 8'hFF, 5'd31, 7'd127);
        issue(tmtw_pkg::KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0);
        issue(tmtw_pkg::KIND_PUT, 8'h7E, 5'd0, 7'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       attr_value = 8'h00;
                1:       attr_value = 8'hFF;
                5:       attr_value = tmtw_pkg::ATTR_RESET;
                default: attr_value = 8'($urandom_range(0, 255));
            endcase
            write_attr(attr_value);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel  = $urandom_range(0, 999);
                code = 8'($urandom);
                row  = 5'($urandom);
                col  = 7'($urandom);
                if (sel < 620)
                begin
                    kind = tmtw_pkg::KIND_PUT;
                    sub  = $urandom_range(0, 99);
                    if (sub < 18)
                        code = tmtw_pkg::CODE_NEWLINE;
                    else if (sub < 28)
                        code = tmtw_pkg::CODE_BACKSPACE;
                    else if (sub < 88)
                        code = 8'($urandom_range(8'h20, 8'h7E));
                end
                else if (sel < 930)
                begin
                    kind = tmtw_pkg::KIND_READ;
                    if ($urandom_range(0, 9) != 0)
                    begin
                        row = 5'($urandom_range(0, ROWS - 1));
                        col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                end
                else if (sel < 965)
                begin
                    kind = KIND_UNUSED;
                end
                else if (sel < 970)
                begin
                    kind = tmtw_pkg::KIND_CLEAR;
                end
                else
                begin
                    kind = 2'($urandom);
                    if (kind == tmtw_pkg::KIND_CLEAR)
                        kind = tmtw_pkg::KIND_READ;
                end

                no_idle = (phase == 3) && (n >= 30) && (n < 130);
                if (!no_idle && $urandom_range(0, 99) < 30)
                    pause($urandom_range(1, 8));
                issue(kind, code, row, col);
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
